/* design/float_to_scaled_int_quantizer_defines.svh */
// Assertion macros used by the checker file.
`ifndef FLOAT_TO_SCALED_INT_QUANTIZER_DEFINES_SVH
`define FLOAT_TO_SCALED_INT_QUANTIZER_DEFINES_SVH

// Implication checked outside reset.
`define FSIQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Condition checked at every edge, reset included.
`define FSIQ_ASSERT_ALWAYS(label, clk, cond) \
   label: assert property (@(posedge clk) (cond)) \
      else $error("invariant check failed");

`endif

/* design/fsiq_pkg.sv */
`timescale 1ns / 1ps
package fsiq_pkg;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_WIDTH_MODE   = 2'd0;
   localparam logic [1:0] CSR_CLAMP_ENABLE = 2'd1;

   // Width modes
   localparam logic [1:0] MODE_INT8  = 2'd0;
   localparam logic [1:0] MODE_INT16 = 2'd1;
   localparam logic [1:0] MODE_INT32 = 2'd2;
   localparam logic [1:0] MODE_FLOAT = 2'd3;

   localparam int PROD_W  = 55;
   localparam int SHIFT_W = 6;

   localparam logic [30:0] ONE_MAG = 31'h3F80_0000;
   localparam logic [30:0] INF_MAG = 31'h7F80_0000;

   // Outcome class of one word after the front stage
   typedef enum logic [2:0] {
      KIND_ZERO  = 3'd0,
      KIND_SAT   = 3'd1,
      KIND_NAN   = 3'd2,
      KIND_ROUND = 3'd3,
      KIND_PASS  = 3'd4
   } kind_type;

   typedef struct packed {
      logic                 valid;
      logic [1:0]           mode;
      logic                 neg;
      kind_type             kind;
      logic [PROD_W-1:0]    prod;
      logic [SHIFT_W-1:0]   rshift;
      logic [31:0]          pass_bits;
   } prep_type;

   // Full scale 2^(n-1)-1 of an integer mode
   function automatic logic [31:0] mode_scale(input logic [1:0] mode);
      logic [31:0] s;
      begin
         case (mode)
            MODE_INT8:  s = 32'h0000_007F;
            MODE_INT16: s = 32'h0000_7FFF;
            default:    s = 32'h7FFF_FFFF;
         endcase
         return s;
      end
   endfunction

endpackage

/* design/fsiq_prep.sv */
`timescale 1ns / 1ps
module fsiq_prep import fsiq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] in_bits,
   input  logic [1:0]  width_mode,
   input  logic        clamp_enable,
   output prep_type    prep
);

   prep_type          prep_ff;
   prep_type          prep_in;
   logic [7:0]        ex;
   logic [22:0]       fr;
   logic [PROD_W-1:0] m_ext;
   logic [30:0]       mag_bits;

   assign ex       = in_bits[30:23];
   assign fr       = in_bits[22:0];
   assign m_ext    = {31'd0, (ex != 8'd0), fr};
   assign mag_bits = in_bits[30:0];

   // Classify the word and form the exact product m * scale
   always_comb begin
      prep_in        = '0;
      prep_in.valid  = in_valid;
      prep_in.mode   = width_mode;
      prep_in.neg    = in_bits[31];
      prep_in.rshift = SHIFT_W'(8'd149 - ex);
      case (width_mode)
         MODE_INT8:  prep_in.prod = (m_ext << 7) - m_ext;
         MODE_INT16: prep_in.prod = (m_ext << 15) - m_ext;
         default:    prep_in.prod = (m_ext << 31) - m_ext;
      endcase
      prep_in.pass_bits = in_bits;
      if (width_mode == MODE_FLOAT) begin
         prep_in.kind = KIND_PASS;
         if (clamp_enable && mag_bits <= INF_MAG && mag_bits > ONE_MAG) begin
            prep_in.pass_bits = {in_bits[31], ONE_MAG};
         end
      end else if (ex == 8'hFF) begin
         prep_in.kind = (fr != 23'd0) ? KIND_NAN : KIND_SAT;
      end else if (ex == 8'd0 || ex <= 8'd90) begin
         prep_in.kind = KIND_ZERO;
      end else if (ex >= 8'd150) begin
         prep_in.kind = KIND_SAT;
      end else begin
         prep_in.kind = KIND_ROUND;
      end
   end

   // Advance the front stage
   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff.valid <= 1'b0;
      end else begin
         prep_ff.valid <= prep_in.valid;
      end
      prep_ff.mode      <= prep_in.mode;
      prep_ff.neg       <= prep_in.neg;
      prep_ff.kind      <= prep_in.kind;
      prep_ff.prod      <= prep_in.prod;
      prep_ff.rshift    <= prep_in.rshift;
      prep_ff.pass_bits <= prep_in.pass_bits;
   end

   assign prep = prep_ff;

endmodule

/* design/fsiq_round.sv */
`timescale 1ns / 1ps
module fsiq_round import fsiq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  prep_type    prep,
   output logic        out_valid,
   output logic [31:0] out_code
);

   logic              valid_ff;
   logic [31:0]       code_ff;
   logic [31:0]       code_in;
   logic [31:0]       scale;
   logic [PROD_W-1:0] shifted;
   logic [PROD_W:0]   rounded;
   logic [31:0]       mag;

   assign scale   = mode_scale(prep.mode);
   // Shift down to one bit below the point, then add half and drop it
   assign shifted = prep.prod >> prep.rshift;
   assign rounded = {1'b0, shifted} + {{PROD_W{1'b0}}, 1'b1};

   always_comb begin
      if (rounded[PROD_W:1] > {23'd0, scale}) begin
         mag = scale;
      end else begin
         mag = rounded[32:1];
      end
      case (prep.kind)
         KIND_PASS:  code_in = prep.pass_bits;
         KIND_NAN:   code_in = 32'd0 - (scale + 32'd1);
         KIND_SAT:   code_in = prep.neg ? 32'd0 - scale : scale;
         KIND_ROUND: code_in = prep.neg ? 32'd0 - mag : mag;
         default:    code_in = 32'd0;
      endcase
   end

   // Hold the result word for its single strobe cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= prep.valid;
      end
      code_ff <= code_in;
   end

   assign out_valid = valid_ff;
   assign out_code  = code_ff;

endmodule

/* design/float_to_scaled_int_quantizer.sv */
`timescale 1ns / 1ps
// Channel   Ports                                    Handshake
// req       start, busy, req_value_bits              taken when start & !busy
// rsp       rsp_strobe, rsp_code                     one cycle, no back-pressure
// csr       csr_write_enable, csr_index, csr_data    written when enable high
//
// One word is taken every cycle; busy stays low.
// Words pass through three registers: input register, product register, result register.
// The product is a shift and subtract, the round a barrel shift and add.
// Synchronous reset clears the valid bits and sets width_mode 1, clamp_enable 1.
// The receiver cannot stall; each result shows for exactly one cycle.
module float_to_scaled_int_quantizer import fsiq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_value_bits,
   output logic        rsp_strobe,
   output logic [31:0] rsp_code,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [1:0]  csr_data
);

   logic        in_valid_ff;
   logic [31:0] in_bits_ff;
   logic [1:0]  width_mode_ff;
   logic        clamp_enable_ff;
   prep_type    prep;

   // Never hold off a word
   assign busy = 1'b0;

   // Capture the incoming word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
      in_bits_ff <= req_value_bits;
   end

   // Configuration registers; other indexes drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         width_mode_ff   <= MODE_INT16;
         clamp_enable_ff <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WIDTH_MODE:   width_mode_ff   <= csr_data;
            CSR_CLAMP_ENABLE: clamp_enable_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   fsiq_prep u_prep (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (in_valid_ff),
      .in_bits      (in_bits_ff),
      .width_mode   (width_mode_ff),
      .clamp_enable (clamp_enable_ff),
      .prep         (prep)
   );

   fsiq_round u_round (
      .clock     (clock),
      .reset     (reset),
      .prep      (prep),
      .out_valid (rsp_strobe),
      .out_code  (rsp_code)
   );

endmodule

/* design/fsiq_checker.sv */
`timescale 1ns / 1ps
`include "float_to_scaled_int_quantizer_defines.svh"
module fsiq_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe
);

   // Each accepted word gives a result once through the input, product and result registers
   `FSIQ_ASSERT_IMPLY(a_accept_gives_result, clock, reset, start && !busy, ##3 rsp_strobe)
   // No result without an accepted word
   `FSIQ_ASSERT_IMPLY(a_no_spurious_result, clock, reset, !(start && !busy), ##3 !rsp_strobe)
   // Nothing comes out in the cycle after reset
   `FSIQ_ASSERT_ALWAYS(a_quiet_after_reset, clock, reset || !$past(reset) || !rsp_strobe)

endmodule

bind float_to_scaled_int_quantizer fsiq_checker u_fsiq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);

/* tb/tb_float_to_scaled_int_quantizer.sv */
`timescale 1ns / 1ps
module tb_float_to_scaled_int_quantizer;
   import fsiq_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int N_RANDOM    = 1000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_value_bits = '0;
   logic        rsp_strobe;
   logic [31:0] rsp_code;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [1:0]  csr_data = '0;

   // Words waiting to go in, and codes waiting to come out
   logic [31:0] pending_words[$];
   logic [31:0] expected_codes[$];

   // Predictor's copy of the registers
   logic [1:0] cur_mode  = MODE_INT16;
   logic       cur_clamp = 1'b1;

   int  n_fail = 0;
   int  n_codes = 0;
   int  n_words = 0;
   int  gap_left = 0;
   int  idle_cycles = 0;
   bit  feeding = 1'b0;

   float_to_scaled_int_quantizer dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_value_bits(req_value_bits), .rsp_strobe(rsp_strobe), .rsp_code(rsp_code),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Integer quantization of one float at n bits, exact rounding of the product
   function automatic logic [31:0] quantize_word(logic [31:0] v, int nbits);
      logic [63:0] scale;
      logic [63:0] mant;
      logic [63:0] prod;
      logic [63:0] mag;
      logic [7:0]  ex;
      int          ex_shift;
      begin
         scale = (64'd1 << (nbits - 1)) - 64'd1;
         ex = v[30:23];
         if (ex == 8'hFF && v[22:0] != 0)
            return 32'd0 - (32'd1 << (nbits - 1));
         if (ex == 8'hFF) begin
            mag = scale;
         end else begin
            mant = (ex == 0) ? {41'd0, v[22:0]} : {40'd0, 1'b1, v[22:0]};
            ex_shift = (ex == 0) ? 149 : 150 - int'(ex);
            prod = mant * scale;
            if (prod == 0) mag = 0;
            else if (ex_shift <= 0) mag = scale;
            else if (ex_shift >= 60) mag = 0;
            else begin
               mag = (prod + (64'd1 << (ex_shift - 1))) >> ex_shift;
               if (mag > scale) mag = scale;
            end
         end
         return v[31] ? 32'd0 - mag[31:0] : mag[31:0];
      end
   endfunction

   function automatic logic [31:0] predict_code(logic [31:0] v);
      begin
         case (cur_mode)
            MODE_INT8:  return quantize_word(v, 8);
            MODE_INT16: return quantize_word(v, 16);
            MODE_INT32: return quantize_word(v, 32);
            default: begin
               if (!cur_clamp || v[30:0] > INF_MAG) return v;
               if (v[30:0] > ONE_MAG) return {v[31], ONE_MAG};
               return v;
            end
         endcase
      end
   endfunction

   function automatic int pick_gap();
      int r;
      begin
         r = $urandom_range(0, 99);
         if (r < 55) return 0;
         if (r < 92) return $urandom_range(1, 3);
         return $urandom_range(4, 25);
      end
   endfunction

   // Random word biased towards the interesting exponents around one
   function automatic logic [31:0] random_word();
      logic [31:0] w;
      int r;
      begin
         w = $urandom;
         r = $urandom_range(0, 9);
         if (r < 5) w[30:23] = 8'd96 + 8'($urandom_range(0, 40));
         else if (r == 5) w[30:23] = 8'h00;
         else if (r == 6) w[30:23] = 8'hFF;
         else if (r == 7) begin
            // exact half steps for tie rounding
            w[30:23] = 8'd120 + 8'($urandom_range(0, 6));
            w[15:0] = 16'h0;
         end
         return w;
      end
   endfunction

   // Append one word to the pending queue
   task automatic add_word(logic [31:0] w);
      begin
         pending_words = {pending_words, w};
      end
   endtask

   // Driver: hand out queued words with random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         start <= 1'b1;
      end else begin
         if (start) begin
            expected_codes = {expected_codes, predict_code(req_value_bits)};
            n_words++;
         end
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (feeding && pending_words.size() > 0) begin
            req_value_bits <= pending_words.pop_front();
            start <= 1'b1;
            gap_left <= pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: compare every strobed code with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         n_codes++;
         if (expected_codes.size() == 0) begin
            $error("unexpected word: code actual %h", rsp_code);
            n_fail++;
         end else begin
            logic [31:0] want;
            want = expected_codes.pop_front();
            if (rsp_code !== want) begin
               $error("code mismatch: expected %h actual %h", want, rsp_code);
               n_fail++;
            end
         end
      end
   end

   // Watchdog on cycles with no word accepted either way
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("FAIL float_to_scaled_int_quantizer");
         $finish;
      end
   end

   task automatic drain();
      begin
         while (pending_words.size() > 0 || start) @(posedge clock);
         while (expected_codes.size() > 0) @(posedge clock);
         repeat (6) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [1:0] idx, logic [1:0] data);
      begin
         drain();
         feeding = 1'b0;
         csr_write_enable <= 1'b1;
         csr_index <= idx;
         csr_data <= data;
         @(posedge clock);
         csr_write_enable <= 1'b0;
         if (idx == CSR_WIDTH_MODE) cur_mode = data;
         else if (idx == CSR_CLAMP_ENABLE) cur_clamp = data[0];
         @(posedge clock);
         feeding = 1'b1;
      end
   endtask

   task automatic queue_directed();
      begin
         add_word(32'h0000_0000);
         add_word(32'h8000_0000);
         add_word(32'h3F80_0000);
         add_word(32'hBF80_0000);
         add_word(32'h3F7F_FFFF);
         add_word(32'h3F00_0000);
         add_word(32'hBF00_0000);
         add_word(32'h7F80_0000);
         add_word(32'hFF80_0000);
         add_word(32'h7FC0_0000);
         add_word(32'hFFFF_FFFF);
         add_word(32'h0000_0001);
         add_word(32'h807F_FFFF);
         add_word(32'h7F7F_FFFF);
         add_word(32'h3F80_0001);
         add_word(32'hC000_0000);
         add_word(32'h3C01_0204);
         add_word(32'h3800_0000);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      feeding = 1'b1;

      // Directed extremes in every mode and clamp setting, reset values first
      queue_directed();
      write_reg(CSR_WIDTH_MODE, MODE_INT8);
      queue_directed();
      write_reg(CSR_WIDTH_MODE, MODE_INT32);
      queue_directed();
      write_reg(CSR_WIDTH_MODE, MODE_FLOAT);
      queue_directed();
      write_reg(CSR_CLAMP_ENABLE, 2'd0);
      queue_directed();
      // Index beyond the registers must be ignored
      write_reg(2'd2, 2'd1);
      write_reg(2'd3, 2'd3);
      queue_directed();
      write_reg(CSR_CLAMP_ENABLE, 2'd1);

      // Random phases across settings
      for (int ph = 0; ph < 10; ph++) begin
         write_reg(CSR_WIDTH_MODE, 2'($urandom_range(0, 3)));
         write_reg(CSR_CLAMP_ENABLE, 2'($urandom_range(0, 3)));
         for (int i = 0; i < N_RANDOM / 10; i++) add_word(random_word());
      end

      feeding = 1'b1;
      drain();
      $display("Ran %0d words through all width modes and clamp settings, %0d codes checked.",
               n_words, n_codes);
      if (n_fail == 0 && expected_codes.size() == 0)
         $display("PASS float_to_scaled_int_quantizer");
      else
         $display("FAIL float_to_scaled_int_quantizer");
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/fsiq_pkg.sv
design/fsiq_prep.sv
design/fsiq_round.sv
design/float_to_scaled_int_quantizer.sv
design/fsiq_checker.sv
tb/tb_float_to_scaled_int_quantizer.sv
